FILE: hw/rtl/tpdp_pkg.sv
package tpdp_pkg;

  // Activation width and the widths that follow from it.
  localparam int ACT_WIDTH    = 16;
  localparam int TRITS        = 5;
  localparam int CODE_LIMIT   = 243;
  // Five activations of ACT_WIDTH bits, each possibly negated, need three more bits.
  localparam int GROUP_WIDTH  = ACT_WIDTH + 3;
  localparam int SUM_WIDTH    = 32;
  localparam int WIDE_WIDTH   = SUM_WIDTH + 1;

  // Digit codes: the digit value itself, weight is digit minus one.
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  typedef logic [TRITS-1:0][1:0] trits_t;
  typedef trits_t [255:0] trit_table_t;
  typedef logic signed [ACT_WIDTH-1:0] act_t;
  typedef act_t [TRITS-1:0] act_vec_t;
  typedef logic signed [GROUP_WIDTH-1:0] group_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;

  // Handshake and marker of the group register towards the accumulator.
  typedef struct packed {
    logic valid;
    logic last;
  } grp_ctl_t;

  // Built at elaboration: base-3 digits of every byte value, least significant
  // first. Bytes past the largest five-digit value decode to all-zero weights.
  function automatic trit_table_t build_trit_table();
    trit_table_t tab;
    int          c;
    for (int i = 0; i < 256; i++) begin
      c = i;
      for (int k = 0; k < TRITS; k++) begin
        if (i < CODE_LIMIT) begin
          tab[i][k] = 2'(c % 3);
          c         = c / 3;
        end else begin
          tab[i][k] = TRIT_ZERO;
        end
      end
    end
    return tab;
  endfunction

  localparam trit_table_t TRIT_TABLE = build_trit_table();

endpackage

FILE: hw/rtl/tpdp_group_stage.sv
module tpdp_group_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 packed_weights,
  input  tpdp_pkg::act_vec_t         acts,
  input  logic                       last_group,
  input  logic                       grp_take,
  output tpdp_pkg::grp_ctl_t         grp_ctl,
  output tpdp_pkg::group_t           grp_sum
);

  logic               s1_valid;
  logic [7:0]         s1_code;
  tpdp_pkg::act_vec_t s1_acts;
  logic               s1_last;
  logic               s2_valid;
  logic               s2_last;
  tpdp_pkg::group_t   s2_sum;

  logic               s2_free;
  logic               s1_move;
  logic               s1_free;
  logic               in_take;
  tpdp_pkg::trits_t   trits;
  tpdp_pkg::group_t   group_next;
  tpdp_pkg::group_t   term;

  assign s2_free  = !s2_valid || grp_take;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_move;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && s1_free;

  assign trits = tpdp_pkg::TRIT_TABLE[s1_code];

  // Each digit adds, subtracts or skips its activation.
  always_comb begin
    group_next = '0;
    for (int k = 0; k < tpdp_pkg::TRITS; k++) begin
      case (trits[k])
        tpdp_pkg::TRIT_POS: term = tpdp_pkg::group_t'(s1_acts[k]);
        tpdp_pkg::TRIT_NEG: term = -tpdp_pkg::group_t'(s1_acts[k]);
        default:            term = '0;
      endcase
      group_next = group_next + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code <= packed_weights;
      s1_acts <= acts;
      s1_last <= last_group;
    end
    if (s1_move) begin
      s2_sum  <= group_next;
      s2_last <= s1_last;
    end
  end

  assign grp_ctl.valid = s2_valid;
  assign grp_ctl.last  = s2_last;
  assign grp_sum       = s2_sum;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && !grp_take))
    else $error("input stalled while the pipeline had room");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted request not held in the input register");

  a_held_group_kept: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !grp_take) |=> (s2_valid && $stable(s2_sum) && $stable(s2_last)))
    else $error("group register changed before the accumulator took it");

endmodule

FILE: hw/rtl/tpdp_accum.sv
module tpdp_accum (
  input  logic               clk,
  input  logic               rst,
  input  tpdp_pkg::grp_ctl_t grp_ctl,
  input  tpdp_pkg::group_t   grp_sum,
  output logic               grp_take,
  output logic               out_valid,
  input  logic               out_stall,
  output tpdp_pkg::sum_t     dot_sum
);

  localparam logic signed [tpdp_pkg::WIDE_WIDTH-1:0] SUM_MAX =
    {2'b00, {(tpdp_pkg::SUM_WIDTH-1){1'b1}}};
  localparam logic signed [tpdp_pkg::WIDE_WIDTH-1:0] SUM_MIN =
    {2'b11, {(tpdp_pkg::SUM_WIDTH-1){1'b0}}};

  tpdp_pkg::sum_t                          running_sum;
  logic signed [tpdp_pkg::WIDE_WIDTH-1:0]  wide_sum;
  tpdp_pkg::sum_t                          total;
  logic                                    out_free;

  assign wide_sum = tpdp_pkg::WIDE_WIDTH'(running_sum) + tpdp_pkg::WIDE_WIDTH'(grp_sum);

  always_comb begin
    if (wide_sum > SUM_MAX) begin
      total = SUM_MAX[tpdp_pkg::SUM_WIDTH-1:0];
    end else if (wide_sum < SUM_MIN) begin
      total = SUM_MIN[tpdp_pkg::SUM_WIDTH-1:0];
    end else begin
      total = wide_sum[tpdp_pkg::SUM_WIDTH-1:0];
    end
  end

  // Groups that do not close a row never wait for the output register.
  assign out_free = !out_valid || !out_stall;
  assign grp_take = grp_ctl.valid && (!grp_ctl.last || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= grp_take && grp_ctl.last;
      end
      if (grp_take) begin
        running_sum <= grp_ctl.last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take && grp_ctl.last) begin
      dot_sum <= total;
    end
  end

  a_reset_clears_sum: assert property (@(posedge clk)
    rst |=> (running_sum == '0 && !out_valid))
    else $error("reset left accumulator or result pending");

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    (grp_take && grp_ctl.last) |=> (running_sum == '0 && out_valid))
    else $error("row end did not clear the accumulator and offer a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(grp_take && grp_ctl.last))
    else $error("pending result overwritten");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(grp_take && grp_ctl.last))
    else $error("result offered without a closing group");

endmodule

FILE: hw/rtl/ternary_packed_dot_product.sv
// Ternary packed dot product, five base-3 weights to a byte.
// Input channel: in_valid / in_stall with packed_weights, act0..act4 and
// last_group. A request is taken at a rising edge with in_valid high and
// in_stall low. The byte is split into five base-3 digits, least significant
// first; each digit selects subtract, skip or add for its activation, and
// bytes from 243 upwards contribute nothing.
// Output channel: out_valid / out_stall with dot_sum, one request per row,
// issued for the group marked last_group; the accumulator then starts again
// from zero. The running total saturates to the signed 32-bit range.
// Path: a closing group passes through the input register, the group
// register and the result register before it is offered.
// Throughput: one group per cycle while in_stall is low; the accumulator
// add and clamp is the single loop.
// Reset (rst, synchronous) empties the pipeline and clears the accumulator.
// When the receiver stalls, the result register holds its value; groups that
// do not close a row keep flowing, and the input stalls only once a closing
// group is waiting behind the held result and both stages are full.
module ternary_packed_dot_product (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          packed_weights,
  input  logic signed [tpdp_pkg::ACT_WIDTH-1:0] act0,
  input  logic signed [tpdp_pkg::ACT_WIDTH-1:0] act1,
  input  logic signed [tpdp_pkg::ACT_WIDTH-1:0] act2,
  input  logic signed [tpdp_pkg::ACT_WIDTH-1:0] act3,
  input  logic signed [tpdp_pkg::ACT_WIDTH-1:0] act4,
  input  logic                                last_group,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  dot_sum
);

  tpdp_pkg::act_vec_t  acts;
  tpdp_pkg::grp_ctl_t  grp_ctl;
  tpdp_pkg::group_t    grp_sum;
  logic                grp_take;
  tpdp_pkg::sum_t      sum_out;

  // Activation k belongs to base-3 digit k.
  assign acts[0] = act0;
  assign acts[1] = act1;
  assign acts[2] = act2;
  assign acts[3] = act3;
  assign acts[4] = act4;

  // Input register, digit decode and five-way add into the group register.
  tpdp_group_stage u_group (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .packed_weights (packed_weights),
    .acts           (acts),
    .last_group     (last_group),
    .grp_take       (grp_take),
    .grp_ctl        (grp_ctl),
    .grp_sum        (grp_sum)
  );

  // Saturating accumulator and result register.
  tpdp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .grp_ctl   (grp_ctl),
    .grp_sum   (grp_sum),
    .grp_take  (grp_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dot_sum   (sum_out)
  );

  assign dot_sum = sum_out;

endmodule

FILE: test/tb_ternary_packed_dot_product.sv
`timescale 1ns / 1ps

module tb_ternary_packed_dot_product;

  // Idling styles shared by the sending and the receiving side.
  localparam int PACE_NONE   = 0;
  localparam int PACE_FULL   = 1;
  localparam int PACE_BURSTY = 2;

  localparam int MAX_WAIT      = 12;
  localparam int RANDOM_GROUPS = 1030;
  // Length of the rows that push the accumulator steadily in one direction.
  localparam int LONG_GROUPS   = 40;
  localparam int QUIET_LIMIT   = 1000;
  localparam int TAIL_CYCLES   = 8;

  localparam tpdp_pkg::sum_t SUM_HI = {1'b0, {(tpdp_pkg::SUM_WIDTH-1){1'b1}}};
  localparam tpdp_pkg::sum_t SUM_LO = {1'b1, {(tpdp_pkg::SUM_WIDTH-1){1'b0}}};

  localparam tpdp_pkg::act_t ACT_HI = {1'b0, {(tpdp_pkg::ACT_WIDTH-1){1'b1}}};
  localparam tpdp_pkg::act_t ACT_LO = {1'b1, {(tpdp_pkg::ACT_WIDTH-1){1'b0}}};

  // Byte values with a known meaning: all digits 0, all digits 1, all digits 2.
  localparam logic [7:0] CODE_ALL_NEG  = 8'd0;
  localparam logic [7:0] CODE_ALL_ZERO = 8'd121;
  localparam logic [7:0] CODE_ALL_POS  = 8'd242;
  localparam logic [7:0] CODE_TOP      = 8'd255;

  // One request on the input channel, together with the idle time that the
  // sender spends before offering it and whether it must first see the
  // result channel run dry.
  typedef struct {
    logic [7:0]          weights;
    tpdp_pkg::act_vec_t  acts;
    logic                last;
    int unsigned         gap;
    bit                  drain_first;
  } weight_group_t;

  logic clk;
  logic rst = 1'b1;

  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [7:0]       packed_weights = '0;
  tpdp_pkg::act_t   act0           = '0;
  tpdp_pkg::act_t   act1           = '0;
  tpdp_pkg::act_t   act2           = '0;
  tpdp_pkg::act_t   act3           = '0;
  tpdp_pkg::act_t   act4           = '0;
  logic             last_group     = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic signed [31:0] dot_sum;

  ternary_packed_dot_product dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .packed_weights (packed_weights),
    .act0           (act0),
    .act1           (act1),
    .act2           (act2),
    .act3           (act3),
    .act4           (act4),
    .last_group     (last_group),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dot_sum        (dot_sum)
  );

  // Requests waiting to be offered, and row sums waiting to come back.
  weight_group_t           pending_groups[$];
  tpdp_pkg::sum_t          expected_sums[$];

  // The request currently on the input channel, and the predicted accumulator.
  weight_group_t           on_bus;
  tpdp_pkg::sum_t          row_acc;
  tpdp_pkg::sum_t          row_total;
  int unsigned             tx_gap;

  int unsigned rx_hold;
  int          rx_mode;

  // Rows predicted is written only by the driver; rows seen is written only
  // by the monitor and with a nonblocking assignment, so the driver always
  // sees the count from before the current edge.
  int rows_predicted = 0;
  int rows_seen      = 0;
  int groups_taken   = 0;
  int clamped_rows   = 0;
  int mismatches     = 0;

  wire in_taken  = in_valid && !in_stall;
  wire out_taken = out_valid && !out_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_wait(input int mode);
    case (mode)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, MAX_WAIT);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
  endfunction

  // The signed sum that one weight byte applies to its five activations. Each
  // base-3 digit, least significant first, subtracts, skips or adds; bytes at
  // or above the code limit have no five-digit meaning and add nothing.
  function automatic longint group_total(input logic [7:0] code,
                                         input tpdp_pkg::act_vec_t acts);
    int unsigned rest;
    int unsigned digit;
    longint      acc;
    acc  = 0;
    rest = code;
    if (code < tpdp_pkg::CODE_LIMIT) begin
      for (int k = 0; k < tpdp_pkg::TRITS; k++) begin
        digit = rest % 3;
        rest  = rest / 3;
        if (digit == tpdp_pkg::TRIT_NEG) begin
          acc -= longint'($signed(acts[k]));
        end else if (digit == tpdp_pkg::TRIT_POS) begin
          acc += longint'($signed(acts[k]));
        end
      end
    end
    return acc;
  endfunction

  function automatic tpdp_pkg::sum_t saturate_sum(input longint v);
    if (v > longint'(SUM_HI)) begin
      return SUM_HI;
    end else if (v < longint'(SUM_LO)) begin
      return SUM_LO;
    end
    return tpdp_pkg::sum_t'(v);
  endfunction

  function automatic tpdp_pkg::act_t rand_act();
    case ($urandom_range(0, 7))
      0:       return ACT_LO;
      1:       return ACT_HI;
      2:       return '0;
      3:       return tpdp_pkg::act_t'($urandom_range(0, 31)) - tpdp_pkg::act_t'(16);
      default: return tpdp_pkg::act_t'($urandom);
    endcase
  endfunction

  function automatic tpdp_pkg::act_vec_t rand_acts();
    tpdp_pkg::act_vec_t v;
    for (int k = 0; k < tpdp_pkg::TRITS; k++) begin
      v[k] = rand_act();
    end
    return v;
  endfunction

  // Mostly proper five-digit codes, with the all-one-sign bytes and the
  // undecodable top codes turning up often enough to matter.
  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 9))
      0:       return CODE_ALL_NEG;
      1:       return CODE_ALL_POS;
      2:       return CODE_ALL_ZERO;
      3:       return 8'($urandom_range(tpdp_pkg::CODE_LIMIT, 255));
      default: return 8'($urandom_range(0, tpdp_pkg::CODE_LIMIT - 1));
    endcase
  endfunction

  // Activations that keep a row moving steadily in one direction.
  function automatic tpdp_pkg::act_vec_t heavy_acts();
    tpdp_pkg::act_vec_t v;
    for (int k = 0; k < tpdp_pkg::TRITS; k++) begin
      v[k] = tpdp_pkg::act_t'($urandom_range(32000, 32767));
    end
    return v;
  endfunction

  task automatic add_group(input logic [7:0] code, input tpdp_pkg::act_vec_t acts,
                           input logic last, input int pace, input bit drain);
    weight_group_t g;
    g.weights     = code;
    g.acts        = acts;
    g.last        = last;
    g.gap         = draw_wait(pace);
    g.drain_first = drain;
    pending_groups.push_back(g);
  endtask

  // Driver. Once the request on the channel has been taken, or while the
  // channel is empty, the next request waits out its own idle time and is
  // then offered and held steady until the block takes it. Every request
  // taken is folded into the predicted accumulator straight away, and a row
  // closing request queues the sum that the result channel must return.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   = 0;
      row_acc  = '0;
    end else begin
      if (in_taken) begin
        groups_taken++;
        row_total = saturate_sum(longint'(row_acc) +
                                 group_total(on_bus.weights, on_bus.acts));
        if (on_bus.last) begin
          expected_sums.push_back(row_total);
          rows_predicted++;
          if (row_total == SUM_HI || row_total == SUM_LO) begin
            clamped_rows++;
          end
          row_acc = '0;
        end else begin
          row_acc = row_total;
        end
        tx_gap = (pending_groups.size() != 0) ? pending_groups[0].gap : 0;
      end
      if (!in_valid || in_taken) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_groups.size() != 0 &&
                     !(pending_groups[0].drain_first && rows_seen != rows_predicted)) begin
          on_bus = pending_groups.pop_front();
          packed_weights <= on_bus.weights;
          act0           <= on_bus.acts[0];
          act1           <= on_bus.acts[1];
          act2           <= on_bus.acts[2];
          act3           <= on_bus.acts[3];
          act4           <= on_bus.acts[4];
          last_group     <= on_bus.last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each row sum taken from the result channel is checked against
  // the oldest prediction. After each one the receiver holds off for a drawn
  // number of cycles, and now and then it changes its style of holding off,
  // so that busy stretches and quiet stretches both occur.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold   = 0;
      rx_mode   = PACE_FULL;
    end else begin
      if (out_taken) begin
        rows_seen <= rows_seen + 1;
        if (expected_sums.size() == 0) begin
          mismatches++;
          $display("%0t: dot_sum expected none, actual %0d", $time, dot_sum);
        end else if (dot_sum !== expected_sums[0]) begin
          mismatches++;
          $display("%0t: dot_sum expected %0d, actual %0d", $time, expected_sums[0], dot_sum);
          void'(expected_sums.pop_front());
        end else begin
          void'(expected_sums.pop_front());
        end
        if ($urandom_range(0, 15) == 0) begin
          rx_mode = $urandom_range(PACE_NONE, PACE_BURSTY);
        end
        rx_hold = draw_wait(rx_mode);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves a request
  // means the block has hung or lost a result.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || in_taken || out_taken) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ternary_packed_dot_product regression: fail");
    $finish;
  end

  initial begin : stimulus
    int pace;
    int row_len;
    int filled;

    // Directed part. Each single-group row isolates one decoding case: the
    // all-negative byte, the all-positive byte, the all-zero byte, the two ends of
    // the undecodable range, each digit position alone adding, and digit 0 alone skipping.
    add_group(CODE_ALL_NEG, '{ACT_HI, ACT_HI, ACT_HI, ACT_HI, ACT_HI}, 1'b1, PACE_NONE, 1'b0);
    add_group(CODE_ALL_NEG, '{ACT_LO, ACT_LO, ACT_LO, ACT_LO, ACT_LO}, 1'b1, PACE_NONE, 1'b0);
    add_group(CODE_ALL_POS, '{ACT_LO, ACT_LO, ACT_LO, ACT_LO, ACT_LO}, 1'b1, PACE_NONE, 1'b0);
    add_group(CODE_ALL_POS, '{ACT_HI, ACT_HI, ACT_HI, ACT_HI, ACT_HI}, 1'b1, PACE_NONE, 1'b0);
    add_group(CODE_ALL_ZERO, '{ACT_HI, ACT_LO, ACT_HI, ACT_LO, ACT_HI}, 1'b1, PACE_NONE, 1'b0);
    add_group(8'(tpdp_pkg::CODE_LIMIT), '{ACT_HI, ACT_HI, ACT_LO, ACT_LO, ACT_HI}, 1'b1,
              PACE_NONE, 1'b0);
    add_group(CODE_TOP, '{ACT_HI, ACT_HI, ACT_HI, ACT_HI, ACT_HI}, 1'b1, PACE_NONE, 1'b0);
    add_group(8'd1, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                      tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    add_group(8'd122, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                        tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    add_group(8'd124, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                        tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    add_group(8'd130, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                        tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    add_group(8'd148, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                        tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    add_group(8'd202, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                        tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b1, PACE_FULL, 1'b0);
    // A row of several groups, closed by a group that adds nothing: it shows
    // that the accumulator carries across groups and is cleared afterwards.
    add_group(CODE_ALL_POS, '{tpdp_pkg::act_t'(5), tpdp_pkg::act_t'(4), tpdp_pkg::act_t'(3),
                              tpdp_pkg::act_t'(2), tpdp_pkg::act_t'(1)}, 1'b0,
              PACE_BURSTY, 1'b0);
    add_group(8'd5, '{ACT_LO, tpdp_pkg::act_t'(-7), tpdp_pkg::act_t'(9), ACT_HI,
                      tpdp_pkg::act_t'(-1)}, 1'b0, PACE_BURSTY, 1'b0);
    add_group(CODE_TOP, '{ACT_HI, ACT_HI, ACT_HI, ACT_HI, ACT_HI}, 1'b1, PACE_BURSTY, 1'b0);
    add_group(8'd77, rand_acts(), 1'b1, PACE_FULL, 1'b0);

    // Random part: well-formed rows of random length and content. The first
    // row, and a few later ones, hold back until every row sum so far has
    // come back, so the block is also seen starting from a drained pipeline.
    pace   = PACE_FULL;
    filled = 0;
    while (filled < RANDOM_GROUPS) begin
      if ($urandom_range(0, 5) == 0) begin
        pace = $urandom_range(PACE_NONE, PACE_BURSTY);
      end
      row_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
      for (int g = 0; g < row_len; g++) begin
        add_group(rand_code(), rand_acts(), g == row_len - 1, pace,
                  g == 0 && (filled == 0 || $urandom_range(0, 19) == 0));
      end
      filled += row_len;
    end

    // A long row of full-scale groups that all add, so the sum climbs far.
    for (int g = 0; g < LONG_GROUPS; g++) begin
      add_group(CODE_ALL_POS, heavy_acts(), g == LONG_GROUPS - 1, PACE_BURSTY, 1'b0);
    end
    // A row that first falls far below zero and is then pulled back up by as
    // many adding groups, so large sums of both signs pass the accumulator.
    for (int g = 0; g < LONG_GROUPS; g++) begin
      add_group(CODE_ALL_NEG, heavy_acts(), 1'b0, PACE_BURSTY, 1'b0);
    end
    for (int g = 0; g < LONG_GROUPS; g++) begin
      add_group(CODE_ALL_POS, heavy_acts(), g == LONG_GROUPS - 1, PACE_FULL, 1'b0);
    end
    // A short row after the long ones checks the clear after a large row.
    add_group(rand_code(), rand_acts(), 1'b0, PACE_FULL, 1'b1);
    add_group(rand_code(), rand_acts(), 1'b1, PACE_FULL, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every row sum to come back, then
    // give the pipeline a few more cycles to show any result it should not.
    while (pending_groups.size() != 0 || in_valid || expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sums.size() != 0) begin
      mismatches++;
      $display("%0t: %0d row sums never arrived", $time, expected_sums.size());
    end

    $display("Sent %0d weight groups forming %0d rows; %0d rows closed at a saturation rail.",
             groups_taken, rows_predicted, clamped_rows);
    $display("Received %0d row sums with %0d mismatches.", rows_seen, mismatches);
    if (mismatches == 0) begin
      $display("ternary_packed_dot_product regression: pass");
    end else begin
      $display("ternary_packed_dot_product regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tpdp_pkg.sv
hw/rtl/tpdp_group_stage.sv
hw/rtl/tpdp_accum.sv
hw/rtl/ternary_packed_dot_product.sv
test/tb_ternary_packed_dot_product.sv
